FILE: src/utrb_pkg.sv
// ----------------------------------------------------------------------------
// utrb_pkg
// Shared types and constants for the UART transmit/receive ring buffers.
// ----------------------------------------------------------------------------
`default_nettype none

package utrb_pkg;

  localparam int unsigned DATA_W     = 8;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned RX_COUNT_W = 6;
  localparam int unsigned TX_COUNT_W = 4;

  // Request codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_TX    = 2'd0,
    CMD_POP_RX     = 2'd1,
    CMD_TX_READY   = 2'd2,
    CMD_RX_ARRIVED = 2'd3
  } cmd_e;

  // Per-request outcome handed from the controller to the output stage
  typedef struct packed {
    logic                  ok;
    logic                  rd_tx;
    logic                  rd_rx;
    logic [RX_COUNT_W-1:0] rx_count;
    logic [TX_COUNT_W-1:0] tx_count;
    logic                  tx_enable;
    logic                  rx_enable;
  } res_t;

endpackage

`default_nettype wire

FILE: src/uart_tx_rx_ring_buffers_core.sv
// ----------------------------------------------------------------------------
// uart_tx_rx_ring_buffers_core
// Transmit and receive byte queues for a UART with host and device requests.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while in_stall_o is low and returns
// one result per request. The accepting edge updates the queue pointers,
// issues the store access and loads the in-flight stage; once the output
// register can load, the read byte is captured from the store's registered
// read port into the output register. Both byte stores are
// synchronous memories left uninitialized after reset; pointers and enables
// reset at once, so no clearing pass is needed. A stall on the result side
// backs up through the single in-flight stage to the request side.
`default_nettype none

module uart_tx_rx_ring_buffers_core #(
  parameter int unsigned TX_DEPTH_LOG2 = 4,
  parameter int unsigned RX_DEPTH_LOG2 = 6
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire logic [utrb_pkg::CMD_W-1:0]      cmd_i,
  input  wire logic [utrb_pkg::DATA_W-1:0]     data_in_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic                            ok_o,
  output      logic [utrb_pkg::DATA_W-1:0]     data_out_o,
  output      logic [utrb_pkg::RX_COUNT_W-1:0] rx_count_o,
  output      logic [utrb_pkg::TX_COUNT_W-1:0] tx_count_o,
  output      logic                            tx_enable_o,
  output      logic                            rx_enable_o
);

  import utrb_pkg::*;

  logic                     accept;
  logic                     tx_we, tx_re, rx_we, rx_re;
  logic [TX_DEPTH_LOG2-1:0] tx_waddr, tx_raddr;
  logic [RX_DEPTH_LOG2-1:0] rx_waddr, rx_raddr;
  logic [DATA_W-1:0]        tx_rdata, rx_rdata, out_data_d;
  res_t                     res;
  logic                     p1_valid_q;
  res_t                     p1_res_q;
  logic                     out_valid_q;
  res_t                     out_res_q;
  logic [DATA_W-1:0]        out_data_q;
  logic                     out_load, p1_free;

  // Handshake
  assign out_load   = p1_valid_q && (!out_valid_q || !out_stall_i);
  assign p1_free    = !p1_valid_q || out_load;
  assign in_stall_o = !p1_free;
  assign accept     = in_valid_i && p1_free;

  utrb_ctrl #(
    .TX_DEPTH_LOG2(TX_DEPTH_LOG2),
    .RX_DEPTH_LOG2(RX_DEPTH_LOG2)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .cmd_i      (cmd_i),
    .tx_we_o    (tx_we),
    .tx_waddr_o (tx_waddr),
    .tx_re_o    (tx_re),
    .tx_raddr_o (tx_raddr),
    .rx_we_o    (rx_we),
    .rx_waddr_o (rx_waddr),
    .rx_re_o    (rx_re),
    .rx_raddr_o (rx_raddr),
    .res_o      (res)
  );

  utrb_ram #(
    .ADDR_W(TX_DEPTH_LOG2),
    .DATA_W(DATA_W)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_waddr),
    .wdata_i (data_in_i),
    .re_i    (tx_re),
    .raddr_i (tx_raddr),
    .rdata_o (tx_rdata)
  );

  utrb_ram #(
    .ADDR_W(RX_DEPTH_LOG2),
    .DATA_W(DATA_W)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_waddr),
    .wdata_i (data_in_i),
    .re_i    (rx_re),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  // Pick the byte read for this request
  always_comb begin
    if (p1_res_q.rd_tx) begin
      out_data_d = tx_rdata;
    end else if (p1_res_q.rd_rx) begin
      out_data_d = rx_rdata;
    end else begin
      out_data_d = '0;
    end
  end

  // In-flight stage and output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (p1_free) begin
        p1_valid_q <= accept;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      p1_res_q <= res;
    end
    if (out_load) begin
      out_res_q  <= p1_res_q;
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = out_res_q.ok;
  assign data_out_o  = out_data_q;
  assign rx_count_o  = out_res_q.rx_count;
  assign tx_count_o  = out_res_q.tx_count;
  assign tx_enable_o = out_res_q.tx_enable;
  assign rx_enable_o = out_res_q.rx_enable;

`ifndef NO_ASSERTIONS
  // A request waiting on a stalled output stays in flight
  a_p1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_valid_q && !out_load) |=> p1_valid_q)
    else $error("in-flight request lost");

  // A delivered byte implies a successful read request
  a_data_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_data_q != '0)) |-> out_res_q.ok)
    else $error("byte delivered on failed request");

  // A request flagged to read must be a successful one
  a_read_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_valid_q && (p1_res_q.rd_tx || p1_res_q.rd_rx)) |-> p1_res_q.ok)
    else $error("read flagged on failed request");
`endif

endmodule

`default_nettype wire

FILE: src/utrb_ram.sv
// ----------------------------------------------------------------------------
// utrb_ram
// Byte store with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module utrb_ram #(
  parameter int unsigned ADDR_W = 4,
  parameter int unsigned DATA_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [DATA_W-1:0] rdata_o
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/utrb_ctrl.sv
// ----------------------------------------------------------------------------
// utrb_ctrl
// Queue pointers, event enables and request decode for both ring buffers.
// ----------------------------------------------------------------------------
`default_nettype none

module utrb_ctrl #(
  parameter int unsigned TX_DEPTH_LOG2 = 4,
  parameter int unsigned RX_DEPTH_LOG2 = 6
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       accept_i,
  input  wire logic [utrb_pkg::CMD_W-1:0] cmd_i,
  output      logic                       tx_we_o,
  output      logic [TX_DEPTH_LOG2-1:0]   tx_waddr_o,
  output      logic                       tx_re_o,
  output      logic [TX_DEPTH_LOG2-1:0]   tx_raddr_o,
  output      logic                       rx_we_o,
  output      logic [RX_DEPTH_LOG2-1:0]   rx_waddr_o,
  output      logic                       rx_re_o,
  output      logic [RX_DEPTH_LOG2-1:0]   rx_raddr_o,
  output      utrb_pkg::res_t             res_o
);

  import utrb_pkg::*;

  logic [TX_DEPTH_LOG2-1:0] tx_wp_q, tx_wp_d, tx_rp_q, tx_rp_d, tx_wp_inc, tx_diff;
  logic [RX_DEPTH_LOG2-1:0] rx_wp_q, rx_wp_d, rx_rp_q, rx_rp_d, rx_wp_inc, rx_diff;
  logic                     tx_en_q, tx_en_d, rx_en_q, rx_en_d;
  logic                     tx_full, tx_empty, rx_full, rx_empty;
  logic                     ok, rd_tx, rd_rx;

  // Queue status
  assign tx_wp_inc = tx_wp_q + 1'b1;
  assign rx_wp_inc = rx_wp_q + 1'b1;
  assign tx_full   = (tx_wp_inc == tx_rp_q);
  assign tx_empty  = (tx_wp_q == tx_rp_q);
  assign rx_full   = (rx_wp_inc == rx_rp_q);
  assign rx_empty  = (rx_wp_q == rx_rp_q);

  // Decode the request and advance pointers
  always_comb begin
    tx_wp_d = tx_wp_q;
    tx_rp_d = tx_rp_q;
    rx_wp_d = rx_wp_q;
    rx_rp_d = rx_rp_q;
    tx_en_d = tx_en_q;
    rx_en_d = rx_en_q;
    tx_we_o = 1'b0;
    tx_re_o = 1'b0;
    rx_we_o = 1'b0;
    rx_re_o = 1'b0;
    ok      = 1'b0;
    rd_tx   = 1'b0;
    rd_rx   = 1'b0;
    if (accept_i) begin
      case (cmd_e'(cmd_i))
        CMD_PUSH_TX: begin
          if (!tx_full) begin
            tx_we_o = 1'b1;
            tx_wp_d = tx_wp_inc;
            tx_en_d = 1'b1;
            ok      = 1'b1;
          end
        end
        CMD_POP_RX: begin
          if (!rx_empty) begin
            rx_re_o = 1'b1;
            rx_rp_d = rx_rp_q + 1'b1;
            rx_en_d = 1'b1;
            ok      = 1'b1;
            rd_rx   = 1'b1;
          end
        end
        CMD_TX_READY: begin
          if (tx_en_q) begin
            if (tx_empty) begin
              tx_en_d = 1'b0;
            end else begin
              tx_re_o = 1'b1;
              tx_rp_d = tx_rp_q + 1'b1;
              ok      = 1'b1;
              rd_tx   = 1'b1;
            end
          end
        end
        CMD_RX_ARRIVED: begin
          if (rx_en_q) begin
            if (rx_full) begin
              rx_en_d = 1'b0;
            end else begin
              rx_we_o = 1'b1;
              rx_wp_d = rx_wp_inc;
              ok      = 1'b1;
            end
          end
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
  end

  assign tx_waddr_o = tx_wp_q;
  assign tx_raddr_o = tx_rp_q;
  assign rx_waddr_o = rx_wp_q;
  assign rx_raddr_o = rx_rp_q;

  // Report fill levels after the request, folded to the field widths
  assign tx_diff = tx_wp_d - tx_rp_d;
  assign rx_diff = rx_wp_d - rx_rp_d;

  always_comb begin
    res_o.ok        = ok;
    res_o.rd_tx     = rd_tx;
    res_o.rd_rx     = rd_rx;
    res_o.rx_count  = RX_COUNT_W'(rx_diff);
    res_o.tx_count  = TX_COUNT_W'(tx_diff);
    res_o.tx_enable = tx_en_d;
    res_o.rx_enable = rx_en_d;
  end

  // Pointer and enable registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_wp_q <= '0;
      tx_rp_q <= '0;
      rx_wp_q <= '0;
      rx_rp_q <= '0;
      tx_en_q <= 1'b1;
      rx_en_q <= 1'b1;
    end else begin
      tx_wp_q <= tx_wp_d;
      tx_rp_q <= tx_rp_d;
      rx_wp_q <= rx_wp_d;
      rx_rp_q <= rx_rp_d;
      tx_en_q <= tx_en_d;
      rx_en_q <= rx_en_d;
    end
  end

`ifndef NO_ASSERTIONS
  // Never read a store entry that is not occupied
  a_tx_read_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_re_o |-> (tx_wp_q != tx_rp_q))
    else $error("transmit read from empty queue");

  a_rx_read_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_re_o |-> (rx_wp_q != rx_rp_q))
    else $error("receive read from empty queue");

  // Only a transmitter-ready request on an empty queue drops the enable
  a_tx_en_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(tx_en_q) |-> $past(accept_i && (cmd_i == CMD_TX_READY) && tx_empty))
    else $error("transmit enable cleared without cause");

  // Only a byte-arrived request on a full queue drops the enable
  a_rx_en_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(rx_en_q) |-> $past(accept_i && (cmd_i == CMD_RX_ARRIVED) && rx_full))
    else $error("receive enable cleared without cause");
`endif

endmodule

`default_nettype wire
